// ===== rtl/thcs_pkg.sv =====
package thcs_pkg;

   localparam int FIELD_WIDTH  = 32;
   localparam int ACT_WIDTH    = 2;
   localparam int STATUS_WIDTH = 2;

   // hit kinds
   localparam logic [ACT_WIDTH-1:0] ACT_STRIP = 2'd0;
   localparam logic [ACT_WIDTH-1:0] ACT_PIXEL = 2'd1;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ZDET = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SAT  = 2'd2;

   // classified hit, fields already clamped to the value range
   typedef struct packed {
      logic [ACT_WIDTH-1:0]   action;
      logic                   ovf;
      logic [FIELD_WIDTH-1:0] track_x;
      logic [FIELD_WIDTH-1:0] track_y;
      logic [FIELD_WIDTH-1:0] cov_xx;
      logic [FIELD_WIDTH-1:0] cov_xy;
      logic [FIELD_WIDTH-1:0] cov_yy;
      logic [FIELD_WIDTH-1:0] meas_a;
      logic [FIELD_WIDTH-1:0] meas_b;
      logic [FIELD_WIDTH-1:0] sigma_a;
      logic [FIELD_WIDTH-1:0] sigma_b;
      logic [FIELD_WIDTH-1:0] cross_var;
   } thcs_item_type;

   // per-beat control that rides along the back pipeline
   typedef struct packed {
      logic valid;
      logic strip;
      logic pixel;
      logic ovf;
      logic zdet;
      logic dz;
      logic neg;
   } thcs_ctrl_type;

endpackage

// ===== rtl/thcs_req_if.sv =====
interface thcs_req_if;
   import thcs_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [ACT_WIDTH-1:0]          action;
   logic signed [FIELD_WIDTH-1:0] track_x;
   logic signed [FIELD_WIDTH-1:0] track_y;
   logic signed [FIELD_WIDTH-1:0] cov_xx;
   logic signed [FIELD_WIDTH-1:0] cov_xy;
   logic signed [FIELD_WIDTH-1:0] cov_yy;
   logic signed [FIELD_WIDTH-1:0] meas_a;
   logic signed [FIELD_WIDTH-1:0] meas_b;
   logic signed [FIELD_WIDTH-1:0] sigma_a;
   logic signed [FIELD_WIDTH-1:0] sigma_b;
   logic signed [FIELD_WIDTH-1:0] cross_var;

   modport source (
      output valid, action, track_x, track_y, cov_xx, cov_xy, cov_yy,
             meas_a, meas_b, sigma_a, sigma_b, cross_var,
      input  ready
   );
   modport sink (
      input  valid, action, track_x, track_y, cov_xx, cov_xy, cov_yy,
             meas_a, meas_b, sigma_a, sigma_b, cross_var,
      output ready
   );

endinterface

// ===== rtl/thcs_rsp_if.sv =====
interface thcs_rsp_if;
   import thcs_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] chi_square;
   logic [STATUS_WIDTH-1:0]       status;

   modport source (output valid, chi_square, status, input ready);
   modport sink   (input valid, chi_square, status, output ready);

endinterface

// ===== rtl/thcs_front.sv =====
module thcs_front import thcs_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   thcs_req_if.sink      req,
   input  logic          full,
   output logic          push,
   output thcs_item_type item
);

   localparam longint HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
   localparam longint LO = -HI - 64'sd1;

   // {overflow, clamped field}
   function automatic logic [FIELD_WIDTH:0] clamp(input logic [FIELD_WIDTH-1:0] f);
      logic signed [63:0] v;
      v = {{(64-FIELD_WIDTH){f[FIELD_WIDTH-1]}}, f};
      if (v > HI) begin
         clamp = {1'b1, HI[FIELD_WIDTH-1:0]};
      end else if (v < LO) begin
         clamp = {1'b1, LO[FIELD_WIDTH-1:0]};
      end else begin
         clamp = {1'b0, f};
      end
   endfunction

   logic [FIELD_WIDTH:0] c_x, c_y, c_xx, c_xy, c_yy, c_ma, c_mb, c_sa, c_sb, c_cv;

   assign c_x  = clamp(req.track_x);
   assign c_y  = clamp(req.track_y);
   assign c_xx = clamp(req.cov_xx);
   assign c_xy = clamp(req.cov_xy);
   assign c_yy = clamp(req.cov_yy);
   assign c_ma = clamp(req.meas_a);
   assign c_mb = clamp(req.meas_b);
   assign c_sa = clamp(req.sigma_a);
   assign c_sb = clamp(req.sigma_b);
   assign c_cv = clamp(req.cross_var);

   assign req.ready = !full;
   assign push      = req.valid && !full;

   always_comb begin
      item.action    = req.action;
      item.ovf       = c_x[FIELD_WIDTH] | c_y[FIELD_WIDTH] | c_xx[FIELD_WIDTH]
                     | c_xy[FIELD_WIDTH] | c_yy[FIELD_WIDTH] | c_ma[FIELD_WIDTH]
                     | c_mb[FIELD_WIDTH] | c_sa[FIELD_WIDTH] | c_sb[FIELD_WIDTH]
                     | c_cv[FIELD_WIDTH];
      item.track_x   = c_x[FIELD_WIDTH-1:0];
      item.track_y   = c_y[FIELD_WIDTH-1:0];
      item.cov_xx    = c_xx[FIELD_WIDTH-1:0];
      item.cov_xy    = c_xy[FIELD_WIDTH-1:0];
      item.cov_yy    = c_yy[FIELD_WIDTH-1:0];
      item.meas_a    = c_ma[FIELD_WIDTH-1:0];
      item.meas_b    = c_mb[FIELD_WIDTH-1:0];
      item.sigma_a   = c_sa[FIELD_WIDTH-1:0];
      item.sigma_b   = c_sb[FIELD_WIDTH-1:0];
      item.cross_var = c_cv[FIELD_WIDTH-1:0];
   end

endmodule

// ===== rtl/thcs_queue.sv =====
module thcs_queue import thcs_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  thcs_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output thcs_item_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   thcs_item_type     slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      push && !pop && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a write");

endmodule

// ===== rtl/thcs_mul.sv =====
module thcs_mul #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [VALUE_WIDTH-1:0] a,
   input  logic signed [VALUE_WIDTH-1:0] b,
   output logic signed [VALUE_WIDTH-1:0] prod,
   output logic                          ovf
);

   localparam int W  = VALUE_WIDTH;
   localparam int H  = (W + 1) / 2;
   localparam int L  = W - H;
   localparam int PW = 2 * W;
   localparam logic [PW-1:0] LIM_POS = PW'({(W-1){1'b1}});
   localparam logic [PW-1:0] LIM_NEG = LIM_POS + 1'b1;
   localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]     mag_a, mag_b;
   logic [2*H-1:0]   p00_ff;
   logic [W-1:0]     p01_ff, p10_ff;
   logic [2*L-1:0]   p11_ff;
   logic             neg_ff;
   logic [PW-1:0]    full_sum, shifted;
   logic [W-1:0]     prod_in;
   logic             ovf_in;

   assign mag_a = a[W-1] ? W'(-a) : W'(a);
   assign mag_b = b[W-1] ? W'(-b) : W'(b);

   // partial products of the magnitudes
   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff <= a[W-1] ^ b[W-1];
         p00_ff <= mag_a[H-1:0] * mag_b[H-1:0];
         p01_ff <= mag_a[H-1:0] * mag_b[W-1:H];
         p10_ff <= mag_a[W-1:H] * mag_b[H-1:0];
         p11_ff <= mag_a[W-1:H] * mag_b[W-1:H];
      end
   end

   always_comb begin
      full_sum = PW'(p00_ff) + (PW'(p01_ff) << H) + (PW'(p10_ff) << H)
               + (PW'(p11_ff) << (2 * H));
      shifted  = full_sum >> FRAC_BITS;
      ovf_in   = 1'b0;
      if (shifted > (neg_ff ? LIM_NEG : LIM_POS)) begin
         ovf_in  = 1'b1;
         prod_in = neg_ff ? MINV : MAXV;
      end else begin
         prod_in = neg_ff ? -shifted[W-1:0] : shifted[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod <= prod_in;
         ovf  <= ovf_in;
      end
   end

endmodule

// ===== rtl/thcs_div.sv =====
module thcs_div import thcs_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic [VALUE_WIDTH-1:0]              num_mag,
   input  logic [VALUE_WIDTH-1:0]              den_mag,
   input  thcs_ctrl_type                       ctl_in,
   output logic [VALUE_WIDTH+FRAC_BITS-1:0]    quo,
   output thcs_ctrl_type                       ctl_out
);

   localparam int W  = VALUE_WIDTH;
   localparam int DW = VALUE_WIDTH + FRAC_BITS;

   logic [W-1:0]   rem_ff [1:DW];
   logic [W-1:0]   den_ff [1:DW];
   logic [DW-1:0]  dvd_ff [1:DW];
   logic [DW-1:0]  quo_ff [1:DW];
   thcs_ctrl_type  ctl_ff [1:DW];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic [W-1:0]  src_rem, src_den, trial;
      logic [DW-1:0] src_dvd, src_quo;
      thcs_ctrl_type src_ctl;
      logic          take;

      if (k == 0) begin : g_first
         assign src_rem = '0;
         assign src_den = den_mag;
         assign src_dvd = {num_mag, {FRAC_BITS{1'b0}}};
         assign src_quo = '0;
         assign src_ctl = ctl_in;
      end else begin : g_next
         assign src_rem = rem_ff[k];
         assign src_den = den_ff[k];
         assign src_dvd = dvd_ff[k];
         assign src_quo = quo_ff[k];
         assign src_ctl = ctl_ff[k];
      end

      assign trial = {src_rem[W-2:0], src_dvd[DW-1]};
      assign take  = (trial >= src_den);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1] <= '0;
         end else if (enable) begin
            ctl_ff[k+1] <= src_ctl;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= take ? trial - src_den : trial;
            den_ff[k+1] <= src_den;
            dvd_ff[k+1] <= {src_dvd[DW-2:0], 1'b0};
            quo_ff[k+1] <= {src_quo[DW-2:0], take};
         end
      end
   end

   assign quo     = quo_ff[DW];
   assign ctl_out = ctl_ff[DW];

endmodule

// ===== rtl/thcs_back.sv =====
module thcs_back import thcs_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  thcs_item_type head,
   input  logic          empty,
   output logic          pop,
   thcs_rsp_if.source    rsp
);

   localparam int W  = VALUE_WIDTH;
   localparam int DW = VALUE_WIDTH + FRAC_BITS;
   localparam logic signed [W+1:0] MAXE = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0] MINE = ~MAXE;
   localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};
   localparam logic [DW-1:0] LIM_POS = DW'({(W-1){1'b1}});
   localparam logic [DW-1:0] LIM_NEG = LIM_POS + 1'b1;
   localparam longint OUT_HI = 64'sd2147483647;
   localparam longint OUT_LO = -OUT_HI - 64'sd1;

   typedef logic signed [W-1:0] val_type;

   function automatic logic signed [W+1:0] ext(input val_type v);
      ext = {{2{v[W-1]}}, v};
   endfunction

   // {overflow, saturated value}
   function automatic logic [W:0] sat(input logic signed [W+1:0] v);
      if (v > MAXE) begin
         sat = {1'b1, MAXE[W-1:0]};
      end else if (v < MINE) begin
         sat = {1'b1, MINE[W-1:0]};
      end else begin
         sat = {1'b0, v[W-1:0]};
      end
   endfunction

   function automatic val_type wid(input logic [FIELD_WIDTH-1:0] f);
      wid = W'($signed(f));
   endfunction

   logic en;

   // ---------------- level 1 products
   val_type        m1a [6], m1b [6], p [6];
   logic [5:0]     p_ovf;
   thcs_ctrl_type  ctl1_in, ctl1_ff, ctl2_ff;
   thcs_item_type  it1_ff, it2_ff;

   assign en  = !rsp.valid || rsp.ready;
   assign pop = en && !empty;

   always_comb begin
      ctl1_in       = '0;
      ctl1_in.valid = !empty;
      ctl1_in.strip = !empty && (head.action == ACT_STRIP);
      ctl1_in.pixel = !empty && (head.action == ACT_PIXEL);
      ctl1_in.ovf   = head.ovf;
      for (int k = 0; k < 6; k++) begin
         m1a[k] = '0;
         m1b[k] = '0;
      end
      if (ctl1_in.strip) begin
         m1a[0] = wid(head.sigma_a); m1b[0] = wid(head.sigma_a);
         m1a[1] = wid(head.meas_b);  m1b[1] = wid(head.meas_b);
         m1a[2] = wid(head.sigma_b); m1b[2] = wid(head.sigma_b);
         m1a[3] = wid(head.meas_b);  m1b[3] = wid(head.sigma_b);
         m1a[4] = wid(head.track_x); m1b[4] = wid(head.meas_b);
         m1a[5] = wid(head.track_y); m1b[5] = wid(head.sigma_b);
      end else if (ctl1_in.pixel) begin
         m1a[0] = wid(head.sigma_a); m1b[0] = wid(head.sigma_a);
         m1a[1] = wid(head.sigma_b); m1b[1] = wid(head.sigma_b);
      end
   end

   for (genvar k = 0; k < 6; k++) begin : g_mul1
      thcs_mul #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
         .clock(clock), .enable(en), .a(m1a[k]), .b(m1b[k]),
         .prod(p[k]), .ovf(p_ovf[k])
      );
   end

   // ---------------- level 2 sums, then products
   val_type        m2a_in [6], m2b_in [6], m2a_ff [6], m2b_ff [6], q [6];
   logic [5:0]     q_ovf;
   val_type        k0_in, k1_in, k0_ff, k1_ff, k0_d1_ff, k1_d1_ff, k0_d2_ff, k1_d2_ff;
   thcs_ctrl_type  ctla2_in, ctla2_ff, ctlm2a_ff, ctlm2b_ff;
   logic [W:0]     s_cs2, s_t, s_ru, s_a, s_d, s_b, s_rx, s_ry;

   always_comb begin
      ctla2_in     = ctl2_ff;
      ctla2_in.ovf = ctl2_ff.ovf | (|p_ovf);
      s_cs2 = sat(ext(p[3]) + ext(p[3]));
      s_t   = sat(ext(wid(it2_ff.meas_a)) - ext(p[4]));
      s_ru  = sat(ext(s_t[W-1:0]) - ext(p[5]));
      s_a   = sat(ext(p[0]) - ext(wid(it2_ff.cov_xx)));
      s_d   = sat(ext(p[1]) - ext(wid(it2_ff.cov_yy)));
      s_b   = sat(ext(wid(it2_ff.cross_var)) - ext(wid(it2_ff.cov_xy)));
      s_rx  = sat(ext(wid(it2_ff.meas_a)) - ext(wid(it2_ff.track_x)));
      s_ry  = sat(ext(wid(it2_ff.meas_b)) - ext(wid(it2_ff.track_y)));
      k0_in = '0;
      k1_in = '0;
      for (int k = 0; k < 6; k++) begin
         m2a_in[k] = '0;
         m2b_in[k] = '0;
      end
      if (ctl2_ff.strip) begin
         ctla2_in.ovf = ctla2_in.ovf | s_cs2[W] | s_t[W] | s_ru[W];
         m2a_in[0] = p[1];          m2b_in[0] = wid(it2_ff.cov_xx);
         m2a_in[1] = s_cs2[W-1:0];  m2b_in[1] = wid(it2_ff.cov_xy);
         m2a_in[2] = p[2];          m2b_in[2] = wid(it2_ff.cov_yy);
         m2a_in[3] = s_ru[W-1:0];   m2b_in[3] = s_ru[W-1:0];
         k0_in     = p[0];
      end else if (ctl2_ff.pixel) begin
         ctla2_in.ovf = ctla2_in.ovf | s_a[W] | s_d[W] | s_b[W] | s_rx[W] | s_ry[W];
         m2a_in[0] = s_a[W-1:0];  m2b_in[0] = s_d[W-1:0];
         m2a_in[1] = s_b[W-1:0];  m2b_in[1] = s_b[W-1:0];
         m2a_in[2] = s_rx[W-1:0]; m2b_in[2] = s_d[W-1:0];
         m2a_in[3] = s_ry[W-1:0]; m2b_in[3] = s_b[W-1:0];
         m2a_in[4] = s_ry[W-1:0]; m2b_in[4] = s_a[W-1:0];
         m2a_in[5] = s_rx[W-1:0]; m2b_in[5] = s_b[W-1:0];
         k0_in     = s_rx[W-1:0];
         k1_in     = s_ry[W-1:0];
      end
   end

   for (genvar k = 0; k < 6; k++) begin : g_mul2
      thcs_mul #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
         .clock(clock), .enable(en), .a(m2a_ff[k]), .b(m2b_ff[k]),
         .prod(q[k]), .ovf(q_ovf[k])
      );
   end

   // ---------------- level 3 sums, then products
   val_type        m3a_in [2], m3b_in [2], m3a_ff [2], m3b_ff [2], r [2];
   logic [1:0]     r_ovf;
   val_type        n3_in, d3_in, n3_ff, d3_ff, n3_d1_ff, d3_d1_ff, n3_d2_ff, d3_d2_ff;
   thcs_ctrl_type  ctla3_in, ctla3_ff, ctlm3a_ff, ctlm3b_ff;
   logic [W:0]     s_e1, s_e2, s_e3, s_det, s_t1, s_t2;

   always_comb begin
      ctla3_in     = ctlm2b_ff;
      ctla3_in.ovf = ctlm2b_ff.ovf | (|q_ovf);
      s_e1  = sat(ext(k0_d2_ff) - ext(q[0]));
      s_e2  = sat(ext(s_e1[W-1:0]) - ext(q[1]));
      s_e3  = sat(ext(s_e2[W-1:0]) - ext(q[2]));
      s_det = sat(ext(q[0]) - ext(q[1]));
      s_t1  = sat(ext(q[2]) - ext(q[3]));
      s_t2  = sat(ext(q[4]) - ext(q[5]));
      n3_in = '0;
      d3_in = '0;
      for (int k = 0; k < 2; k++) begin
         m3a_in[k] = '0;
         m3b_in[k] = '0;
      end
      if (ctlm2b_ff.strip) begin
         ctla3_in.ovf = ctla3_in.ovf | s_e1[W] | s_e2[W] | s_e3[W];
         n3_in = q[3];
         d3_in = s_e3[W-1:0];
      end else if (ctlm2b_ff.pixel) begin
         ctla3_in.ovf = ctla3_in.ovf | s_det[W] | s_t1[W] | s_t2[W];
         d3_in     = s_det[W-1:0];
         m3a_in[0] = s_t1[W-1:0]; m3b_in[0] = k0_d2_ff;
         m3a_in[1] = s_t2[W-1:0]; m3b_in[1] = k1_d2_ff;
      end
   end

   for (genvar k = 0; k < 2; k++) begin : g_mul3
      thcs_mul #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
         .clock(clock), .enable(en), .a(m3a_ff[k]), .b(m3b_ff[k]),
         .prod(r[k]), .ovf(r_ovf[k])
      );
   end

   // ---------------- numerator, denominator, divider
   thcs_ctrl_type  ctl4, div_ctl;
   val_type        num4, den4;
   logic [W:0]     s_num;
   logic [W-1:0]   num_mag, den_mag;
   logic [DW-1:0]  div_quo;

   always_comb begin
      ctl4     = ctlm3b_ff;
      ctl4.ovf = ctlm3b_ff.ovf | (|r_ovf);
      s_num    = sat(ext(r[0]) + ext(r[1]));
      num4     = '0;
      den4     = W'(1);
      if (ctlm3b_ff.strip) begin
         num4 = n3_d2_ff;
         if (d3_d2_ff == '0) begin
            ctl4.dz = 1'b1;
         end else begin
            den4 = d3_d2_ff;
         end
      end else if (ctlm3b_ff.pixel) begin
         ctl4.ovf = ctl4.ovf | s_num[W];
         num4     = s_num[W-1:0];
         if (d3_d2_ff == '0) begin
            ctl4.zdet = 1'b1;
         end else begin
            den4 = d3_d2_ff;
         end
      end
      ctl4.neg = num4[W-1] ^ den4[W-1];
      num_mag  = num4[W-1] ? W'(-num4) : W'(num4);
      den_mag  = den4[W-1] ? W'(-den4) : W'(den4);
   end

   thcs_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .enable(en),
      .num_mag(num_mag), .den_mag(den_mag), .ctl_in(ctl4),
      .quo(div_quo), .ctl_out(div_ctl)
   );

   // ---------------- result saturation and output register
   logic                          out_valid_ff;
   logic signed [FIELD_WIDTH-1:0] chi_ff, chi_in;
   logic [STATUS_WIDTH-1:0]       status_ff, status_in;
   val_type                       val;
   logic signed [63:0]            v64;
   logic                          ovf_f;

   always_comb begin
      ovf_f = div_ctl.ovf | div_ctl.dz;
      if (div_quo > (div_ctl.neg ? LIM_NEG : LIM_POS)) begin
         ovf_f = 1'b1;
         val   = div_ctl.neg ? MINV : MAXV;
      end else begin
         val = div_ctl.neg ? -div_quo[W-1:0] : div_quo[W-1:0];
      end
      if (div_ctl.dz) begin
         val = MAXV;
      end
      if (!div_ctl.strip && !div_ctl.pixel) begin
         val = '0;
      end
      v64 = 64'(val);
      if (v64 > OUT_HI) begin
         ovf_f  = 1'b1;
         chi_in = OUT_HI[FIELD_WIDTH-1:0];
      end else if (v64 < OUT_LO) begin
         ovf_f  = 1'b1;
         chi_in = OUT_LO[FIELD_WIDTH-1:0];
      end else begin
         chi_in = v64[FIELD_WIDTH-1:0];
      end
      priority if (ovf_f) begin
         status_in = STATUS_SAT;
      end else if (div_ctl.zdet) begin
         status_in = STATUS_ZDET;
      end else begin
         status_in = STATUS_OK;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.chi_square = chi_ff;
   assign rsp.status     = status_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff      <= '0;
         ctl2_ff      <= '0;
         ctla2_ff     <= '0;
         ctlm2a_ff    <= '0;
         ctlm2b_ff    <= '0;
         ctla3_ff     <= '0;
         ctlm3a_ff    <= '0;
         ctlm3b_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         ctl1_ff      <= ctl1_in;
         ctl2_ff      <= ctl1_ff;
         ctla2_ff     <= ctla2_in;
         ctlm2a_ff    <= ctla2_ff;
         ctlm2b_ff    <= ctlm2a_ff;
         ctla3_ff     <= ctla3_in;
         ctlm3a_ff    <= ctla3_ff;
         ctlm3b_ff    <= ctlm3a_ff;
         out_valid_ff <= div_ctl.valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         it1_ff   <= head;
         it2_ff   <= it1_ff;
         m2a_ff   <= m2a_in;
         m2b_ff   <= m2b_in;
         k0_ff    <= k0_in;
         k1_ff    <= k1_in;
         k0_d1_ff <= k0_ff;
         k1_d1_ff <= k1_ff;
         k0_d2_ff <= k0_d1_ff;
         k1_d2_ff <= k1_d1_ff;
         m3a_ff   <= m3a_in;
         m3b_ff   <= m3b_in;
         n3_ff    <= n3_in;
         d3_ff    <= d3_in;
         n3_d1_ff <= n3_ff;
         d3_d1_ff <= d3_ff;
         n3_d2_ff <= n3_d1_ff;
         d3_d2_ff <= d3_d1_ff;
         chi_ff   <= chi_in;
         status_ff <= status_in;
      end
   end

endmodule

// ===== rtl/track_hit_chi_square.sv =====
// channel   dir   beat                                       accepted when
// req_bus   in    action, track, covariance, measurement     valid && ready
// rsp_bus   out   chi_square, status                         valid && ready
//
// one hit per cycle sustained while rsp_bus is ready; each hit passes through the
// queue, three product levels, the one-bit-per-stage divider and the output register
// reset is synchronous and active high, it empties the queue and the pipeline
// a stalled result holds the whole back pipeline; the four-beat queue keeps req ready
// until it fills
module track_hit_chi_square import thcs_pkg::*; #(
   parameter int FRAC_BITS   = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   thcs_req_if.sink    req_bus,
   thcs_rsp_if.source  rsp_bus
);

   // front to back queue
   thcs_item_type push_item, head;
   logic          push, pop, queue_full, queue_empty;

   // front: clamps fields to the value range and marks overflow
   thcs_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .req(req_bus), .full(queue_full), .push(push), .item(push_item)
   );

   // short queue so the front keeps taking beats while the back stalls
   thcs_queue #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_item(push_item), .full(queue_full),
      .pop(pop), .empty(queue_empty), .head(head)
   );

   // back: three product levels, pipelined divide, saturation
   thcs_back #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .head(head), .empty(queue_empty), .pop(pop), .rsp(rsp_bus)
   );

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.status == STATUS_OK) || (rsp_bus.status == STATUS_ZDET)
                        || (rsp_bus.status == STATUS_SAT))
      else $error("undefined status code");
   a_ready_queue: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready == !queue_full)
      else $error("req ready disagrees with queue space");

endmodule
